>>> src/absf_pkg.sv
// Shared types and codes for the audio buffer slot FIFO.
package absf_pkg;

  localparam int unsigned CNT_W = 7;

  localparam logic [1:0] FUNC_HDR = 2'd0;
  localparam logic [1:0] FUNC_SMP = 2'd1;
  localparam logic [1:0] FUNC_POP = 2'd2;

  localparam logic [1:0] FILL_IDLE = 2'd0;
  localparam logic [1:0] FILL_BUSY = 2'd1;
  localparam logic [1:0] FILL_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [15:0]       frame_count;
    logic [7:0]        channel_count;
    logic [31:0]       meta_in;
    logic signed [15:0] sample_in;
    logic [CNT_W-1:0]  pop_limit;
  } in_item_t;

  typedef struct packed {
    logic              empty_res;
    logic              has_sample;
    logic signed [15:0] sample_out;
    logic [CNT_W-1:0]  sample_count;
    logic [15:0]       frames_out;
    logic [7:0]        channels_out;
    logic [31:0]       meta_out;
    logic [31:0]       drop_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             hdr_en;
    logic             smp_en;
    logic             out_load;
    logic             emit_empty;
    logic             emit_sample;
    logic             emit_last;
    logic             rp_inc;
    logic [CNT_W-1:0] sample_idx;
    logic [CNT_W-1:0] count;
  } absf_cmd_t;

  typedef struct packed {
    logic             occ_zero;
    logic             out_free;
    logic [CNT_W-1:0] stored_len;
  } absf_status_t;

endpackage

>>> src/absf_ctrl.sv
// Controller: accepts requests and sequences the pop runs.
module absf_ctrl import absf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   func_i,
  input  logic [CNT_W-1:0] pop_limit_i,
  input  absf_status_t status_i,
  output absf_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_META = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             empty_q, empty_d;
  logic             acc;
  logic             is_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign is_last    = (idx_q == count_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    limit_d = limit_q;
    count_d = count_q;
    idx_d   = idx_q;
    empty_d = empty_q;
    cmd_o   = '0;
    cmd_o.hdr_en     = acc && (func_i == FUNC_HDR);
    cmd_o.smp_en     = acc && (func_i == FUNC_SMP);
    cmd_o.count      = count_q;
    cmd_o.sample_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && (func_i == FUNC_POP)) begin
          limit_d = pop_limit_i;
          empty_d = status_i.occ_zero;
          state_d = ST_META;
        end
      end
      ST_META: begin
        // slot info read has landed: clip stored length to the consumer limit
        if (empty_q) begin
          count_d = '0;
        end else if (status_i.stored_len > limit_q) begin
          count_d = limit_q;
        end else begin
          count_d = status_i.stored_len;
        end
        idx_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (empty_q) begin
            cmd_o.emit_empty = 1'b1;
            cmd_o.emit_last  = 1'b1;
            state_d          = ST_IDLE;
          end else if (count_q == '0) begin
            cmd_o.emit_last = 1'b1;
            cmd_o.rp_inc    = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.emit_sample = 1'b1;
            cmd_o.emit_last   = is_last;
            idx_d             = idx_q + CNT_W'(1);
            if (is_last) begin
              cmd_o.rp_inc = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      limit_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
    end
  end

endmodule

>>> src/absf_datapath.sv
// Datapath: slot stores, pointers, fill tracking, drop counter and output stage.
module absf_datapath import absf_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned SLOT_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_item_i,
  input  absf_cmd_t    cmd_i,
  output absf_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_item_o
);

  localparam int unsigned PW    = $clog2(2 * SLOTS);
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int unsigned DEPTH = SLOTS * SLOT_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [PW:0]      SLOTS_W = (PW + 1)'(SLOTS);
  localparam logic [PW:0]      TWO_S   = (PW + 1)'(2 * SLOTS);
  localparam logic [PW-1:0]    PTR_TOP = PW'(2 * SLOTS - 1);
  localparam logic [CNT_W-1:0] MAX_W   = CNT_W'(SLOT_DEPTH);

  logic signed [15:0] sample_mem [DEPTH];
  logic [15:0]        frames_mem [SLOTS];
  logic [7:0]         chans_mem  [SLOTS];
  logic [31:0]        meta_mem   [SLOTS];
  logic [CNT_W-1:0]   len_mem    [SLOTS];

  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [31:0]      drop_q, drop_d;
  logic [1:0]       mode_q, mode_d;
  logic [CNT_W-1:0] fidx_q, fidx_d, target_q, target_d;

  logic [15:0]        rd_frames_q;
  logic [7:0]         rd_chans_q;
  logic [31:0]        rd_meta_q;
  logic [CNT_W-1:0]   rd_len_q;
  logic signed [15:0] rd_sample_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic [PW:0]      occ;
  logic [SW-1:0]    wslot, rslot;
  logic [23:0]      prod;
  logic [CNT_W-1:0] hdr_len;
  logic             hdr_ok;
  logic             smp_ok;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             out_free;

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] ptr);
    logic [PW:0] p;
    p = {1'b0, ptr};
    if (p >= SLOTS_W) begin
      p = p - SLOTS_W;
    end
    return p[SW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    return (ptr == PTR_TOP) ? '0 : ptr + PW'(1);
  endfunction

  assign wslot = slot_of(wp_q);
  assign rslot = slot_of(rp_q);

  always_comb begin
    if (wp_q >= rp_q) begin
      occ = {1'b0, wp_q} - {1'b0, rp_q};
    end else begin
      occ = {1'b0, wp_q} + TWO_S - {1'b0, rp_q};
    end
  end

  assign prod    = 24'(in_item_i.frame_count) * 24'(in_item_i.channel_count);
  assign hdr_len = (prod > {17'd0, MAX_W}) ? MAX_W : prod[CNT_W-1:0];
  assign hdr_ok  = cmd_i.hdr_en && (occ < SLOTS_W);
  assign smp_ok  = cmd_i.smp_en && (mode_q == FILL_BUSY) && (fidx_q < target_q);

  assign wr_addr = AW'(AW'(wslot) * AW'(SLOT_DEPTH) + AW'(fidx_q[IW-1:0]));
  assign rd_addr = AW'(AW'(rslot) * AW'(SLOT_DEPTH) + AW'(cmd_i.sample_idx[IW-1:0]));

  // fill tracking, commit and drop handling
  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    drop_d   = drop_q;
    mode_d   = mode_q;
    fidx_d   = fidx_q;
    target_d = target_q;
    if (cmd_i.hdr_en) begin
      if (!hdr_ok) begin
        drop_d = drop_q + 32'd1;
        mode_d = FILL_DROP;
      end else begin
        fidx_d   = '0;
        target_d = hdr_len;
        if (hdr_len == '0) begin
          wp_d   = ptr_inc(wp_q);
          mode_d = FILL_IDLE;
        end else begin
          mode_d = FILL_BUSY;
        end
      end
    end else if (smp_ok) begin
      fidx_d = fidx_q + CNT_W'(1);
      if (fidx_d >= target_q) begin
        wp_d   = ptr_inc(wp_q);
        mode_d = FILL_IDLE;
      end
    end
    if (cmd_i.rp_inc) begin
      rp_d = ptr_inc(rp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      drop_q   <= '0;
      mode_q   <= FILL_IDLE;
      fidx_q   <= '0;
      target_q <= '0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      drop_q   <= drop_d;
      mode_q   <= mode_d;
      fidx_q   <= fidx_d;
      target_q <= target_d;
    end
  end

  // slot info stores: written by headers, read at the oldest slot
  always_ff @(posedge clk_i) begin
    if (hdr_ok) begin
      frames_mem[wslot] <= in_item_i.frame_count;
      chans_mem[wslot]  <= in_item_i.channel_count;
      meta_mem[wslot]   <= in_item_i.meta_in;
      len_mem[wslot]    <= hdr_len;
    end
    rd_frames_q <= frames_mem[rslot];
    rd_chans_q  <= chans_mem[rslot];
    rd_meta_q   <= meta_mem[rslot];
    rd_len_q    <= len_mem[rslot];
  end

  // sample store: the read register doubles as the output sample, so hold it on stall
  always_ff @(posedge clk_i) begin
    if (smp_ok) begin
      sample_mem[wr_addr] <= in_item_i.sample_in;
    end
    if (cmd_i.out_load && cmd_i.emit_sample) begin
      rd_sample_q <= sample_mem[rd_addr];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cmd_i.out_load) begin
      out_q.empty_res    <= cmd_i.emit_empty;
      out_q.has_sample   <= cmd_i.emit_sample;
      out_q.sample_out   <= '0;
      out_q.sample_count <= cmd_i.count;
      out_q.frames_out   <= cmd_i.emit_empty ? 16'd0 : rd_frames_q;
      out_q.channels_out <= cmd_i.emit_empty ? 8'd0 : rd_chans_q;
      out_q.meta_out     <= cmd_i.emit_empty ? 32'd0 : rd_meta_q;
      out_q.drop_count   <= drop_q;
      out_q.last         <= cmd_i.emit_last;
    end
  end

  always_comb begin
    out_item_o            = out_q;
    out_item_o.sample_out = out_q.has_sample ? rd_sample_q : 16'sd0;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.occ_zero   = (wp_q == rp_q);
  assign status_o.out_free   = out_free;
  assign status_o.stored_len = rd_len_q;

endmodule

>>> src/audio_buffer_slot_fifo.sv
// Top level of the audio buffer slot FIFO.
// Buffers live in SLOTS fixed slots of SLOT_DEPTH samples. A header request
// opens a slot (or counts a drop when every slot holds a committed buffer), and
// sample requests fill it. A pop request first reads the oldest slot's stored
// header through the registered reads of the slot stores, then delivers one result
// per cycle while the consumer keeps taking them: one result for an empty FIFO,
// a zero-length buffer or a pop_limit of zero, otherwise
// min(stored length, pop_limit) samples.
// No new request is taken during a pop run; headers and samples may follow its
// last result while that result still waits at the output. The stores need no
// clearing after reset.
module audio_buffer_slot_fifo import absf_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned SLOT_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  absf_cmd_t    cmd;
  absf_status_t status;

  absf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (in_item_i.func),
    .pop_limit_i (in_item_i.pop_limit),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  absf_datapath #(
    .SLOTS      (SLOTS),
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
